>>> hdl/mbkm_pkg.sv
// Shared types, constants and address decode helpers for the memory bus
// with keyboard matrix. No dependencies.
`default_nettype none

package mbkm_pkg;

    localparam int RAM_AW = 16;
    localparam int ROM_AW = 14;
    localparam int DATA_W = 8;

    localparam logic [RAM_AW-1:0] KEYPORT_ADDR = 16'hDC01;
    localparam logic [RAM_AW-1:0] ROWSEL_ADDR  = 16'hDC00;
    localparam logic [RAM_AW-1:0] RAM_LAST     = 16'hFFFF;
    localparam logic [DATA_W-1:0] ROW_IDLE     = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_READ     = 2'd0,
        FUNC_WRITE    = 2'd1,
        FUNC_ROM_LOAD = 2'd2,
        FUNC_KEY      = 2'd3
    } func_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        SRC_RAM,
        SRC_ROM,
        SRC_KEYS
    } rd_src_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_cmd_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ROM_AW-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } rom_cmd_t;

    // Per-transaction controls from the sequencer to the datapath.
    typedef struct packed {
        logic    read;
        rd_src_t src;
        logic    key_ev;
        logic    sel_we;
    } acc_t;

    // The ROM windows are 0xA000-0xBFFF and 0xE000-0xFFFF.
    function automatic logic in_rom_window(input logic [RAM_AW-1:0] a);
        return a[15] & a[13];
    endfunction

    // The low window maps to entries 0-8191 and the high window above it.
    function automatic logic [ROM_AW-1:0] rom_index(input logic [RAM_AW-1:0] a);
        return {a[14], a[12:0]};
    endfunction

endpackage

`default_nettype wire

>>> hdl/mbkm_spram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module mbkm_spram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/mbkm_keys.sv
// Keyboard matrix, row-select shadow of RAM[0xDC00] and the row scan.
// Depends on mbkm_pkg.
`default_nettype none

module mbkm_keys
    import mbkm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              key_ev,
    input  wire logic [2:0]        key_row,
    input  wire logic [2:0]        key_col,
    input  wire logic              key_down,
    input  wire logic              sel_we,
    input  wire logic [DATA_W-1:0] sel_data,
    output logic      [DATA_W-1:0] scan
);

    logic [DATA_W-1:0] matrix_reg [8];
    logic [DATA_W-1:0] sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 8; r++)
            begin
                matrix_reg[r] <= ROW_IDLE;
            end
            sel_reg <= '0;
        end
        else
        begin
            if (key_ev)
            begin
                matrix_reg[key_row][key_col] <= ~key_down;
            end
            if (sel_we)
            begin
                sel_reg <= sel_data;
            end
        end
    end

    // Rows are active low: a cleared select bit pulls that row into the scan.
    always_comb
    begin
        scan = ROW_IDLE;
        for (int r = 0; r < 8; r++)
        begin
            if (!sel_reg[r])
            begin
                scan = scan & matrix_reg[r];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/mbkm_ctrl.sv
// Sequencer: RAM clearing pass after reset, then decode of each bus
// transaction into memory commands. Depends on mbkm_pkg.
`default_nettype none

module mbkm_ctrl
    import mbkm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic [1:0]        func,
    input  wire logic [RAM_AW-1:0] address,
    input  wire logic [DATA_W-1:0] data,
    input  wire logic              s1_free,
    input  wire logic [DATA_W-1:0] scan,
    output logic                   req_ready,
    output ram_cmd_t               ram_cmd,
    output rom_cmd_t               rom_cmd,
    output acc_t                   acc
);

    state_t            state_reg, state_next;
    logic [RAM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              accept;
    func_t             op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        op           = func_t'(func);
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_ready    = 1'b0;
        accept       = 1'b0;
        ram_cmd      = '{en: 1'b0, we: 1'b0, addr: address, wdata: data};
        rom_cmd      = '{en: 1'b0, we: 1'b0, addr: rom_index(address), wdata: data};
        acc          = '{read: 1'b0, src: SRC_RAM, key_ev: 1'b0, sel_we: 1'b0};

        case (state_reg)
            ST_CLEAR:
            begin
                ram_cmd.en    = 1'b1;
                ram_cmd.we    = 1'b1;
                ram_cmd.addr  = clr_cnt_reg;
                ram_cmd.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RAM_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                req_ready = s1_free;
                accept    = req_valid & s1_free;
                if (accept)
                begin
                    case (op)
                        FUNC_READ:
                        begin
                            acc.read = 1'b1;
                            if (address == KEYPORT_ADDR)
                            begin
                                // The scanned value is also stored back in RAM.
                                acc.src       = SRC_KEYS;
                                ram_cmd.en    = 1'b1;
                                ram_cmd.we    = 1'b1;
                                ram_cmd.wdata = scan;
                            end
                            else if (in_rom_window(address))
                            begin
                                acc.src    = SRC_ROM;
                                rom_cmd.en = 1'b1;
                            end
                            else
                            begin
                                acc.src    = SRC_RAM;
                                ram_cmd.en = 1'b1;
                            end
                        end
                        FUNC_WRITE:
                        begin
                            ram_cmd.en = 1'b1;
                            ram_cmd.we = 1'b1;
                            acc.sel_we = (address == ROWSEL_ADDR);
                        end
                        FUNC_ROM_LOAD:
                        begin
                            rom_cmd.en = in_rom_window(address);
                            rom_cmd.we = 1'b1;
                        end
                        FUNC_KEY:
                        begin
                            acc.key_ev = 1'b1;
                        end
                        default:
                        begin
                            acc.key_ev = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/memory_bus_with_keyboard_matrix.sv
// Top level of the memory bus with keyboard matrix: sequencer, RAM, ROM,
// key matrix and read-result pipeline. Depends on mbkm_pkg and all mbkm_* modules.
//
// Usage: each transaction on the request channel (req_valid/req_ready)
// carries func, address, data, key_row, key_col and key_down. A read
// (func 0) returns one byte on the response channel (rsp_valid/rsp_ready,
// payload read_data); RAM writes, ROM loads and key events return nothing.
// Reads of 0xA000-0xBFFF and 0xE000-0xFFFF come from the ROM, a read of
// 0xDC01 returns the key rows selected by the cleared bits of RAM[0xDC00] and
// stores that byte in RAM, all other reads come from RAM.
//
// Throughput is one transaction per cycle while the result path has room. A
// read result passes through the synchronous memory read register and then
// the output register before it reaches rsp_valid. The memory read register
// and the output register form a two-entry path, so requests keep flowing
// while a result waits. When rsp_ready is low and both entries are full,
// req_ready drops until the output register drains.
//
// After reset the RAM is cleared by a sweep over all 65536 entries, one entry
// per cycle; req_ready stays low for that whole pass. The key matrix resets to
// all released. ROM contents are undefined until loaded.
`default_nettype none

module memory_bus_with_keyboard_matrix
    import mbkm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [1:0]        func,
    input  wire logic [RAM_AW-1:0] address,
    input  wire logic [DATA_W-1:0] data,
    input  wire logic [2:0]        key_row,
    input  wire logic [2:0]        key_col,
    input  wire logic              key_down,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic      [DATA_W-1:0] read_data
);

    ram_cmd_t          ram_cmd;
    rom_cmd_t          rom_cmd;
    acc_t              acc;
    logic [DATA_W-1:0] scan;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] rom_rdata;

    // Stage 1 tracks a read whose memory data is held at the memory read port.
    logic              s1_valid_reg, s1_valid_next;
    rd_src_t           s1_src_reg, s1_src_next;
    logic [DATA_W-1:0] s1_scan_reg, s1_scan_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic              s1_moves;
    logic              s1_free;
    logic              accept;

    assign s1_moves = !out_valid_reg || rsp_ready;
    assign s1_free  = !s1_valid_reg || s1_moves;
    assign accept   = req_valid && req_ready;

    mbkm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (func),
        .address   (address),
        .data      (data),
        .s1_free   (s1_free),
        .scan      (scan),
        .req_ready (req_ready),
        .ram_cmd   (ram_cmd),
        .rom_cmd   (rom_cmd),
        .acc       (acc)
    );

    mbkm_spram #(
        .ADDR_W (RAM_AW),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .en    (ram_cmd.en),
        .we    (ram_cmd.we),
        .addr  (ram_cmd.addr),
        .wdata (ram_cmd.wdata),
        .rdata (ram_rdata)
    );

    mbkm_spram #(
        .ADDR_W (ROM_AW),
        .DATA_W (DATA_W)
    ) u_rom (
        .clk   (clk),
        .en    (rom_cmd.en),
        .we    (rom_cmd.we),
        .addr  (rom_cmd.addr),
        .wdata (rom_cmd.wdata),
        .rdata (rom_rdata)
    );

    mbkm_keys u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_ev   (acc.key_ev),
        .key_row  (key_row),
        .key_col  (key_col),
        .key_down (key_down),
        .sel_we   (acc.sel_we),
        .sel_data (data),
        .scan     (scan)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_src_reg    <= s1_src_next;
        s1_scan_reg   <= s1_scan_next;
        read_data_reg <= read_data_next;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_src_next    = s1_src_reg;
        s1_scan_next   = s1_scan_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;

        // Stage 1 hands over to the output register whenever that one is free or drains.
        if (s1_moves)
        begin
            out_valid_next = s1_valid_reg;
            case (s1_src_reg)
                SRC_RAM:  read_data_next = ram_rdata;
                SRC_ROM:  read_data_next = rom_rdata;
                SRC_KEYS: read_data_next = s1_scan_reg;
                default:  read_data_next = ram_rdata;
            endcase
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = acc.read;
            s1_src_next   = acc.src;
            s1_scan_next  = scan;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

>>> tb/sv/mbkm_bus_checker.sv
// Checker for the memory bus with keyboard matrix: watches both channels,
// keeps its own image of RAM, ROM and key rows, and compares read results.
// Depends on mbkm_pkg.

module mbkm_bus_checker
    import mbkm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire logic [1:0]        func,
    input  wire logic [RAM_AW-1:0] address,
    input  wire logic [DATA_W-1:0] data,
    input  wire logic [2:0]        key_row,
    input  wire logic [2:0]        key_col,
    input  wire logic              key_down,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire logic [DATA_W-1:0] read_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [RAM_AW-1:0] LOW_ROM_FIRST  = 16'hA000;
    localparam logic [RAM_AW-1:0] LOW_ROM_LAST   = 16'hBFFF;
    localparam logic [RAM_AW-1:0] HIGH_ROM_FIRST = 16'hE000;
    localparam int                ROM_HALF       = 8192;
    localparam int                REPORT_LIMIT   = 10;

    logic [DATA_W-1:0] ram_image [0:65535];
    logic [DATA_W-1:0] rom_image [0:16383];
    logic [DATA_W-1:0] key_rows  [0:7];
    logic [DATA_W-1:0] expected_reads [$];
    int                reports;

    // Slot in the ROM image for an address in one of the windows, -1 outside.
    function automatic int rom_slot(input logic [RAM_AW-1:0] a);
        if (a >= LOW_ROM_FIRST && a <= LOW_ROM_LAST)
            return int'(a - LOW_ROM_FIRST);
        if (a >= HIGH_ROM_FIRST)
            return ROM_HALF + int'(a - HIGH_ROM_FIRST);
        return -1;
    endfunction

    // A row takes part in the scan when its bit in the row select byte is low.
    function automatic logic [DATA_W-1:0] scan_key_rows();
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sel;
        acc = ROW_IDLE;
        sel = ram_image[ROWSEL_ADDR];
        for (int r = 0; r < 8; r++)
        begin
            if (!sel[r])
                acc = acc & key_rows[r];
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] value;
        int                slot;
        if (!rst_n)
        begin
            for (int i = 0; i < 65536; i++)
                ram_image[i] = '0;
            for (int i = 0; i < 8; i++)
                key_rows[i] = '1;
            expected_reads.delete();
            fail_count = 0;
            reports    = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    fail_count++;
                    if (reports < REPORT_LIMIT)
                    begin
                        reports++;
                        $display("%0t: read result %02h arrived with none expected",
                                 $time, read_data);
                    end
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_data !== want)
                    begin
                        fail_count++;
                        if (reports < REPORT_LIMIT)
                        begin
                            reports++;
                            $display("%0t: read_data mismatch, expected %02h, got %02h",
                                     $time, want, read_data);
                        end
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                slot = rom_slot(address);
                case (func_t'(func))
                    FUNC_READ:
                    begin
                        if (address == KEYPORT_ADDR)
                        begin
                            value = scan_key_rows();
                            ram_image[KEYPORT_ADDR] = value;
                        end
                        else if (slot >= 0)
                            value = rom_image[slot];
                        else
                            value = ram_image[address];
                        expected_reads.push_back(value);
                    end
                    FUNC_WRITE:
                        ram_image[address] = data;
                    FUNC_ROM_LOAD:
                    begin
                        if (slot >= 0)
                            rom_image[slot] = data;
                    end
                    default:
                        key_rows[key_row][key_col] = !key_down;
                endcase
            end
            pending = expected_reads.size();
        end
    end

endmodule

>>> tb/sv/memory_bus_with_keyboard_matrix_tb.sv
// Testbench top for the memory bus with keyboard matrix: clock, reset,
// request stimulus, response back-pressure and the final verdict.
// Depends on mbkm_pkg, the block itself and mbkm_bus_checker.

module memory_bus_with_keyboard_matrix_tb
    import mbkm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Nothing is accepted during the RAM clearing sweep after reset, so the
    // quiet-cycle limit has to sit well above the length of that sweep.
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int LONG_HOLD      = 64;
    localparam int DRAIN_CYCLES   = 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [1:0]        func      = '0;
    logic [RAM_AW-1:0] address   = '0;
    logic [DATA_W-1:0] data      = '0;
    logic [2:0]        key_row   = '0;
    logic [2:0]        key_col   = '0;
    logic              key_down  = 1'b0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    logic [DATA_W-1:0] read_data;

    int mismatch_count;
    int pending_reads;

    // Knobs shared between the stimulus process and the response process.
    bit idle_on          = 1'b0;
    bit stall_on         = 1'b0;
    bit hold_rsp_request = 1'b0;

    // ROM entries that have been loaded. Reads of ROM addresses that were
    // never loaded are undefined, so the stimulus steers clear of them.
    bit                rom_written [int];
    logic [RAM_AW-1:0] rom_addrs [$];

    memory_bus_with_keyboard_matrix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .func      (func),
        .address   (address),
        .data      (data),
        .key_row   (key_row),
        .key_col   (key_col),
        .key_down  (key_down),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .read_data (read_data)
    );

    mbkm_bus_checker bus_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .func       (func),
        .address    (address),
        .data       (data),
        .key_row    (key_row),
        .key_col    (key_col),
        .key_down   (key_down),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .read_data  (read_data),
        .fail_count (mismatch_count),
        .pending    (pending_reads)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // True for 0xA000-0xBFFF and 0xE000-0xFFFF, where reads come from ROM.
    function automatic bit is_rom_window(input logic [RAM_AW-1:0] a);
        return (a >= 16'hA000 && a <= 16'hBFFF) || a >= 16'hE000;
    endfunction

    // Addresses cluster on a few hot spots so that writes are read back:
    // the bottom of RAM, the row select and key port pair, and the edges
    // of both ROM windows. One pick in four is fully random.
    function automatic logic [RAM_AW-1:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return RAM_AW'($urandom);
            1:       return RAM_AW'($urandom_range(0, 31));
            2:       return ROWSEL_ADDR + RAM_AW'($urandom_range(0, 1));
            default: return ($urandom_range(0, 1) ? 16'hA000 : 16'hFFE0)
                            + RAM_AW'($urandom_range(0, 31));
        endcase
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // When idling is enabled, valid sometimes drops for a short burst first.
    // Valid is never lowered and raised in the same time step.
    task automatic send_access(input func_t f, input logic [RAM_AW-1:0] a,
                               input logic [DATA_W-1:0] d, input logic [2:0] r,
                               input logic [2:0] c, input logic k);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        address   <= a;
        data      <= d;
        key_row   <= r;
        key_col   <= c;
        key_down  <= k;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        // Items are accepted in order, so a load recorded here is always
        // seen by the block before any read that is generated later.
        if (f == FUNC_ROM_LOAD && is_rom_window(a) && !rom_written.exists(int'(a)))
        begin
            rom_written[int'(a)] = 1'b1;
            rom_addrs.push_back(a);
        end
    endtask

    // One random transaction. Reads split between the key port, loaded ROM
    // entries and the address hot spots; a read that would land on an
    // unloaded ROM entry is moved to a loaded one or to the key port.
    task automatic random_access();
        func_t             f;
        logic [RAM_AW-1:0] a;
        int                pick;
        pick = $urandom_range(0, 19);
        a    = pick_address();
        if (pick < 8)
        begin
            f = FUNC_READ;
            case ($urandom_range(0, 3))
                0: a = KEYPORT_ADDR;
                1:
                begin
                    if (rom_addrs.size() > 0)
                        a = rom_addrs[$urandom_range(0, rom_addrs.size() - 1)];
                end
                default: ;
            endcase
            if (is_rom_window(a) && !rom_written.exists(int'(a)))
            begin
                if (rom_addrs.size() > 0)
                    a = rom_addrs[$urandom_range(0, rom_addrs.size() - 1)];
                else
                    a = KEYPORT_ADDR;
            end
        end
        else if (pick < 13)
        begin
            f = FUNC_WRITE;
            // Frequent writes of the row select byte keep the scan varied.
            if ($urandom_range(0, 3) == 0)
                a = ROWSEL_ADDR;
        end
        else if (pick < 16)
        begin
            f = FUNC_ROM_LOAD;
            // Mostly loads into the windows; the rest may fall outside them
            // and must then be ignored by the block.
            if ($urandom_range(0, 3) != 0)
                a = ($urandom_range(0, 1) ? 16'hA000 : 16'hE000)
                    + ($urandom_range(0, 1) ? RAM_AW'($urandom_range(0, 8191))
                                            : RAM_AW'($urandom_range(0, 31)));
        end
        else
            f = FUNC_KEY;
        send_access(f, a, DATA_W'($urandom), 3'($urandom), 3'($urandom),
                    1'($urandom));
    endtask

    // Stops offering transactions until every expected read has come back.
    // The first edge lets the checker count the last accepted transaction.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads != 0)
            @(posedge clk);
    endtask

    // Response side: ready is mostly high, with short random stalls when
    // enabled and one long hold-off on request from the stimulus.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rsp_request)
            begin
                hold_rsp_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL memory_bus_with_keyboard_matrix");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling. The first transaction waits out the
        // RAM clearing sweep. RAM is zero and no key is down at this point.
        send_access(FUNC_READ, 16'h0000, 8'h00, 3'd0, 3'd0, 1'b0);
        // All rows selected, nothing pressed: the key port reads all ones.
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_KEY, 16'h0000, 8'h00, 3'd0, 3'd0, 1'b1);
        send_access(FUNC_KEY, 16'h0000, 8'h00, 3'd7, 3'd7, 1'b1);
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        // Select only the lowest row, then only the highest one.
        send_access(FUNC_WRITE, ROWSEL_ADDR, 8'hFE, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_WRITE, ROWSEL_ADDR, 8'h7F, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        // No row selected at all: the scan must come back as all ones.
        send_access(FUNC_WRITE, ROWSEL_ADDR, ROW_IDLE, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        // A plain write to the key port is overwritten by the next scan.
        send_access(FUNC_WRITE, KEYPORT_ADDR, 8'h12, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, KEYPORT_ADDR, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_KEY, 16'h0000, 8'h00, 3'd0, 3'd0, 1'b0);
        // ROM window edges. The write under the ROM goes to RAM only, so
        // the read that follows still returns the ROM byte.
        send_access(FUNC_ROM_LOAD, 16'hA000, 8'h3C, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_WRITE, 16'hA000, 8'h55, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, 16'hA000, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_ROM_LOAD, 16'hBFFF, 8'hC3, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_ROM_LOAD, 16'hE000, 8'h81, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_ROM_LOAD, 16'hFFFF, 8'hFF, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, 16'hBFFF, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, 16'hE000, 8'h00, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, 16'hFFFF, 8'h00, 3'd0, 3'd0, 1'b0);
        // A ROM load just below the low window changes nothing.
        send_access(FUNC_ROM_LOAD, 16'h9FFF, 8'h77, 3'd0, 3'd0, 1'b0);
        send_access(FUNC_READ, 16'h9FFF, 8'h00, 3'd0, 3'd0, 1'b0);

        // First random phase with idling and stalls on both sides.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (450) random_access();

        // The sender pauses until every read result has arrived.
        wait_for_results();

        // Long response hold-off while requests keep coming back to back,
        // so the result path fills and the request side has to stall.
        idle_on          = 1'b0;
        hold_rsp_request = 1'b1;
        repeat (40) random_access();

        idle_on = 1'b1;
        repeat (450) random_access();

        // Last stretch at full rate on both sides.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        repeat (200) random_access();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_reads == 0)
            $display("PASS memory_bus_with_keyboard_matrix");
        else
            $display("FAIL memory_bus_with_keyboard_matrix");
        $finish;
    end

endmodule
